@@ src/segenc_pkg.sv @@
// Shared types and constants of the signed exp-Golomb encoder.
package segenc_pkg;

    localparam int unsigned ValueW = 31;             // input value width
    localparam int unsigned NumW   = 32;             // mapped number plus 2^k
    localparam int unsigned LenW   = 6;              // bit length of number, 0..32
    localparam int unsigned CodeW  = 64;             // left-aligned code word
    localparam int unsigned CntW   = 7;              // code bits, up to 63
    localparam int unsigned OrderW = 4;              // order k
    localparam int unsigned ByteW  = 8;

    localparam logic ActEncode = 1'b0;
    localparam logic ActFlush  = 1'b1;

    // One job handed from the front to the back through the queue
    typedef struct packed {
        logic             flush;   // flush the pending partial byte
        logic [CodeW-1:0] code;    // code bits, first bit in the MSB
        logic [CntW-1:0]  cnt;     // number of code bits
    } job_t;

endpackage

@@ src/segenc_front.sv @@
// Front pipeline: maps the value, finds its bit length and aligns the code.
module segenc_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [segenc_pkg::OrderW-1:0]         order_k,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  in_action,
    input  logic signed [segenc_pkg::ValueW-1:0]  in_value,
    output logic                                  job_valid,
    input  logic                                  job_ready,
    output segenc_pkg::job_t                      job
);

    // stage A: mapped number plus 2^k
    logic                          a_valid_reg, a_valid_next;
    logic                          a_flush_reg;
    logic [segenc_pkg::NumW-1:0]   a_num_reg;
    // stage B: bit length
    logic                          b_valid_reg, b_valid_next;
    logic                          b_flush_reg;
    logic [segenc_pkg::NumW-1:0]   b_num_reg;
    logic [segenc_pkg::LenW-1:0]   b_len_reg;
    // stage C: aligned code word
    logic                          c_valid_reg, c_valid_next;
    segenc_pkg::job_t              c_job_reg;

    logic a_ready, b_ready, c_ready;
    logic [segenc_pkg::NumW:0]     v_dbl;
    logic [segenc_pkg::NumW:0]     mapped;
    logic [segenc_pkg::NumW-1:0]   a_num_next;
    logic [segenc_pkg::LenW-1:0]   len_next;
    logic [segenc_pkg::CntW-1:0]   nbits;
    logic [segenc_pkg::CntW-1:0]   shamt;
    segenc_pkg::job_t              c_job_next;

    // ready chain from the queue back to the input
    assign c_ready  = !c_valid_reg || job_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    assign a_valid_next = a_ready ? in_valid : a_valid_reg;
    assign b_valid_next = b_ready ? a_valid_reg : b_valid_reg;
    assign c_valid_next = c_ready ? b_valid_reg : c_valid_reg;

    // map: v > 0 -> 2v-1, v <= 0 -> -2v, then add 2^k
    always_comb begin
        v_dbl = {in_value[segenc_pkg::ValueW-1], in_value, 1'b0};
        if (!in_value[segenc_pkg::ValueW-1] && (in_value != '0)) begin
            mapped = v_dbl - 33'd1;
        end else begin
            mapped = 33'd0 - v_dbl;
        end
        a_num_next = mapped[segenc_pkg::NumW-1:0] + (32'd1 << order_k);
    end

    // bit length: position of the highest set bit plus one
    always_comb begin
        len_next = '0;
        for (int i = 0; i < segenc_pkg::NumW; i++) begin
            if (a_num_reg[i]) begin
                len_next = segenc_pkg::LenW'(i + 1);
            end
        end
    end

    // code has 2*len-k-1 bits; number placed so its LSB ends the code
    always_comb begin
        nbits = segenc_pkg::CntW'({b_len_reg, 1'b0}) - segenc_pkg::CntW'(order_k)
                - 7'd1;
        shamt = 7'd64 - nbits;
        c_job_next.flush = b_flush_reg;
        c_job_next.code  = {32'd0, b_num_reg} << shamt;
        c_job_next.cnt   = nbits;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (a_ready) begin
            a_flush_reg <= (in_action == segenc_pkg::ActFlush);
            a_num_reg   <= a_num_next;
        end
        if (b_ready) begin
            b_flush_reg <= a_flush_reg;
            b_num_reg   <= a_num_reg;
            b_len_reg   <= len_next;
        end
        if (c_ready) begin
            c_job_reg <= c_job_next;
        end
    end

    assign job_valid = c_valid_reg;
    assign job       = c_job_reg;

endmodule

@@ src/segenc_fifo.sv @@
// Two-entry job queue between front and back.
module segenc_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  segenc_pkg::job_t  push_job,
    output logic              not_full,
    input  logic              pop,
    output logic              not_empty,
    output segenc_pkg::job_t  pop_job
);

    segenc_pkg::job_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign not_full  = (count_reg != 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_job   = mem[rd_ptr_reg];

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ (push && not_full);
        rd_ptr_next = rd_ptr_reg ^ (pop && not_empty);
        count_next  = count_reg + 2'((push && not_full) ? 1 : 0)
                      - 2'((pop && not_empty) ? 1 : 0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push && not_full) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ src/segenc_back.sv @@
// Back end: packs code bits into bytes and drives the output word register.
module segenc_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_valid,
    output logic                              q_pop,
    input  segenc_pkg::job_t                  q_job,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [segenc_pkg::ByteW-1:0]      m_byte,
    output logic                              m_last
);

    logic                           busy_reg, busy_next;
    segenc_pkg::job_t               job_reg, job_next;
    logic [segenc_pkg::ByteW-1:0]   partial_reg, partial_next;
    logic [2:0]                     fill_reg, fill_next;
    logic                           m_valid_reg, m_valid_next;
    logic [segenc_pkg::ByteW-1:0]   m_byte_reg, m_byte_next;
    logic                           m_last_reg, m_last_next;

    logic                           out_free;
    logic [3:0]                     need;
    logic [segenc_pkg::CntW-1:0]    cnt_left;
    logic [segenc_pkg::ByteW-1:0]   merged;

    assign out_free = !m_valid_reg || m_ready;
    assign need     = 4'd8 - {1'b0, fill_reg};
    assign cnt_left = job_reg.cnt - segenc_pkg::CntW'(need);
    assign merged   = partial_reg | (job_reg.code[63:56] >> fill_reg);

    // load a job, then take up to one byte per cycle from it while the output register is free
    always_comb begin
        busy_next    = busy_reg;
        job_next     = job_reg;
        partial_next = partial_reg;
        fill_next    = fill_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_byte_next  = m_byte_reg;
        m_last_next  = m_last_reg;
        q_pop        = 1'b0;
        if (!busy_reg) begin
            if (q_valid) begin
                q_pop     = 1'b1;
                job_next  = q_job;
                busy_next = 1'b1;
            end
        end else if (out_free) begin
            if (job_reg.flush) begin
                if (fill_reg != 3'd0) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = partial_reg;
                    m_last_next  = 1'b1;
                end
                partial_next = '0;
                fill_next    = 3'd0;
                busy_next    = 1'b0;
            end else if (job_reg.cnt >= segenc_pkg::CntW'(need)) begin
                // a full byte completes
                m_valid_next  = 1'b1;
                m_byte_next   = merged;
                m_last_next   = (cnt_left < 7'd8);
                partial_next  = '0;
                fill_next     = 3'd0;
                job_next.code = job_reg.code << need;
                job_next.cnt  = cnt_left;
                busy_next     = (cnt_left != '0);
            end else begin
                // tail bits stay pending in the partial byte
                partial_next = merged;
                fill_next    = fill_reg + 3'(job_reg.cnt);
                busy_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            partial_reg <= '0;
            fill_reg    <= 3'd0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            partial_reg <= partial_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg    <= job_next;
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid = m_valid_reg;
    assign m_byte  = m_byte_reg;
    assign m_last  = m_last_reg;

endmodule

@@ src/signed_exp_golomb_encoder.sv @@
// Top level of the signed order-k exp-Golomb encoder.
// Input words on s_axis: tdata holds a signed 31-bit value, tuser the action
// (0 encode, 1 flush the pending partial byte). Output words on m_axis carry
// one finished byte each, first code bit in bit 7; tlast marks the last byte
// an input word causes. Encode words that complete no byte, and flushes with
// nothing pending, give no output word.
// A three-stage front (map and add 2^k, bit-length search, code alignment)
// feeds a two-entry job queue; the back end loads a job and then packs one
// byte per cycle while the output word register is free, leaving tail bits
// pending in the partial byte, and loads the next job only when done with
// the current one. The back end sets the throughput.
// order_k is written through cfg_we/cfg_wdata; the user must write it only
// while the block is idle, which the block itself does not enforce.
// Synchronous active-low reset clears the pipeline, queue, output register,
// the partial byte and order_k. When m_axis_tready is low the output word
// holds, the back end stops, and the queue and front fill up before
// s_axis_tready drops.
module signed_exp_golomb_encoder (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [segenc_pkg::OrderW-1:0]        cfg_wdata,     // order_k
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [31:0]                          s_axis_tdata,  // [30:0] value
    input  logic                                 s_axis_tuser,  // action
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [7:0]                           m_axis_tdata,  // [7:0] out_byte
    output logic                                 m_axis_tlast   // last
);

    logic [segenc_pkg::OrderW-1:0] order_k_reg;
    logic                          job_valid, q_not_full, q_not_empty, q_pop;
    segenc_pkg::job_t              front_job, q_job;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_k_reg <= '0;
        end else if (cfg_we) begin
            order_k_reg <= cfg_wdata;
        end
    end

    segenc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .order_k   (order_k_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_action (s_axis_tuser),
        .in_value  (s_axis_tdata[segenc_pkg::ValueW-1:0]),
        .job_valid (job_valid),
        .job_ready (q_not_full),
        .job       (front_job)
    );

    segenc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_valid),
        .push_job  (front_job),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_job   (q_job)
    );

    segenc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_not_empty),
        .q_pop   (q_pop),
        .q_job   (q_job),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_byte  (m_axis_tdata),
        .m_last  (m_axis_tlast)
    );

endmodule
